>>> src/pdmrs_pkg.sv
// shared types, constants and sequence helpers for the pbch dmrs generator
`default_nettype none

package pdmrs_pkg;

  // sequence length and offset of the gold code
  localparam int unsigned LFSR_W      = 31;
  localparam int unsigned GOLD_NC     = 1600;
  localparam int unsigned DEF_NUM_SYM = 144;

  // seed field geometry
  localparam int unsigned CELL_W  = 10;
  localparam int unsigned SSB_W   = 3;
  localparam int unsigned PROD_W  = 13;
  localparam int unsigned HI_SHFT = 11;
  localparam int unsigned LO_SHFT = 6;

  // qpsk amplitudes in q7
  localparam logic signed [7:0] AMP_POS = 8'sd90;
  localparam logic signed [7:0] AMP_NEG = -8'sd90;

  typedef logic [LFSR_W-1:0] lfsr_t;
  typedef lfsr_t jump_cols_t [LFSR_W];

  // input word
  typedef struct packed {
    logic              restart;
    logic [CELL_W-1:0] cell_id;
    logic [SSB_W-1:0]  ssb_index;
  } item_t;

  // result word
  typedef struct packed {
    logic signed [7:0] sym_re;
    logic signed [7:0] sym_im;
    logic              symbol_last;
  } symbol_t;

  // word held between the input stage and the sequence stage
  typedef struct packed {
    logic  restart;
    lfsr_t seed;
  } stage_t;

  // one step of the first register
  function automatic lfsr_t x1_step(input lfsr_t s);
    logic fb;
    fb = s[0] ^ s[3];
    return {fb, s[LFSR_W-1:1]};
  endfunction

  // one step of the second register
  function automatic lfsr_t x2_step(input lfsr_t s);
    logic fb;
    fb = s[0] ^ s[1] ^ s[2] ^ s[3];
    return {fb, s[LFSR_W-1:1]};
  endfunction

  // first register start state, advanced past the offset
  function automatic lfsr_t x1_start_calc();
    lfsr_t s;
    s = lfsr_t'(1);
    for (int unsigned i = 0; i < GOLD_NC; i++) begin
      s = x1_step(s);
    end
    return s;
  endfunction

  // columns of the offset jump for the second register; column j-1 follows
  // from column j by one step, plus the top column where feedback taps bit j
  function automatic jump_cols_t x2_jump_calc();
    jump_cols_t cols;
    lfsr_t      s;
    s = lfsr_t'(1) << (LFSR_W - 1);
    for (int unsigned i = 0; i < GOLD_NC; i++) begin
      s = x2_step(s);
    end
    cols[LFSR_W-1] = s;
    for (int j = LFSR_W - 1; j >= 1; j--) begin
      cols[j-1] = x2_step(cols[j]) ^ ((j <= 3) ? cols[LFSR_W-1] : '0);
    end
    return cols;
  endfunction

  localparam lfsr_t      X1_START = x1_start_calc();
  localparam jump_cols_t X2_JUMP  = x2_jump_calc();

  // scrambling seed from cell id and ssb index
  function automatic lfsr_t seed_calc(input logic [CELL_W-1:0] pci,
                                      input logic [SSB_W-1:0] ssb);
    logic [SSB_W:0]    ssb_p1;
    logic [CELL_W-2:0] grp_p1;
    logic [PROD_W-1:0] prod;
    ssb_p1 = {1'b0, ssb} + (SSB_W+1)'(1);
    grp_p1 = {1'b0, pci[CELL_W-1:2]} + (CELL_W-1)'(1);
    prod   = PROD_W'(ssb_p1) * PROD_W'(grp_p1);
    return (lfsr_t'(prod) << HI_SHFT) + (lfsr_t'(ssb_p1) << LO_SHFT)
           + lfsr_t'(pci[1:0]);
  endfunction

  // apply the offset jump to a seed
  function automatic lfsr_t x2_jump(input lfsr_t seed);
    lfsr_t acc;
    acc = '0;
    for (int unsigned j = 0; j < LFSR_W; j++) begin
      acc = acc ^ (seed[j] ? X2_JUMP[j] : '0);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

>>> src/pdmrs_front.sv
// input register stage: takes a word and forms the scrambling seed
`default_nettype none

module pdmrs_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  pdmrs_pkg::item_t item,
  input  logic             take,
  output logic             stage_valid,
  output pdmrs_pkg::stage_t stage
);
  import pdmrs_pkg::*;

  // hold while the sequence stage does not take the current word
  assign item_stall = stage_valid && !take;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      stage.restart <= item.restart;
      stage.seed    <= seed_calc(item.cell_id, item.ssb_index);
    end
  end

endmodule

`default_nettype wire

>>> src/pdmrs_gold.sv
// sequence stage: gold registers, symbol counter and result register
`default_nettype none

module pdmrs_gold #(
  parameter int unsigned NUM_SYMBOLS = pdmrs_pkg::DEF_NUM_SYM
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               stage_valid,
  input  pdmrs_pkg::stage_t  stage,
  output logic               take,
  output logic               symbol_valid,
  input  logic               symbol_stall,
  output pdmrs_pkg::symbol_t symbol
);
  import pdmrs_pkg::*;

  localparam int unsigned CNT_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SYMBOLS - 1);

  logic             out_free;
  lfsr_t            first_lfsr, second_lfsr;
  lfsr_t            x1_cur, x2_cur;
  logic [CNT_W-1:0] symbol_count, cnt_cur;
  logic             last;

  assign out_free = !symbol_valid || !symbol_stall;
  assign take     = stage_valid && out_free;

  // state seen by this word, reseeded on restart
  always_comb begin
    x1_cur  = stage.restart ? X1_START : first_lfsr;
    x2_cur  = stage.restart ? x2_jump(stage.seed) : second_lfsr;
    cnt_cur = stage.restart ? '0 : symbol_count;
    last    = (cnt_cur == CNT_LAST);
  end

  // sequence state, two bits per symbol
  always_ff @(posedge clk) begin
    if (rst) begin
      first_lfsr   <= X1_START;
      second_lfsr  <= '0;
      symbol_count <= '0;
    end else if (take) begin
      first_lfsr   <= x1_step(x1_step(x1_cur));
      second_lfsr  <= x2_step(x2_step(x2_cur));
      symbol_count <= last ? '0 : cnt_cur + CNT_W'(1);
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_valid <= 1'b0;
    end else if (out_free) begin
      symbol_valid <= stage_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      symbol.sym_re      <= (x1_cur[0] ^ x2_cur[0]) ? AMP_NEG : AMP_POS;
      symbol.sym_im      <= (x1_cur[1] ^ x2_cur[1]) ? AMP_NEG : AMP_POS;
      symbol.symbol_last <= last;
    end
  end

endmodule

`default_nettype wire

>>> src/nr_pbch_dmrs_generator_core.sv
// top level of the nr pbch dmrs generator
`default_nettype none

// PBCH DM-RS source: each accepted word yields one QPSK symbol (+/-90 in Q7
// on each rail) from the length-31 Gold sequence, two sequence bits per
// symbol. A word with restart set forms the seed from cell_id and ssb_index,
// loads the second register through a fixed XOR jump network and restarts
// at symbol 0; symbol_last marks symbol NUM_SYMBOLS-1, after which the
// count wraps and the sequence runs on. One word is accepted every clock
// unless the output stalls; each result passes through the input register,
// then the result register. The seed multiply sits before the input register,
// and the jump network plus the two-step register update before the result
// register.
module nr_pbch_dmrs_generator_core #(
  parameter int unsigned NUM_SYMBOLS = pdmrs_pkg::DEF_NUM_SYM
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  pdmrs_pkg::item_t   item,
  output logic               symbol_valid,
  input  logic               symbol_stall,
  output pdmrs_pkg::symbol_t symbol
);
  import pdmrs_pkg::*;

  logic   take;
  logic   stage_valid;
  stage_t stage;

  // input register and seed
  pdmrs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .take        (take),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  // sequence and result register
  pdmrs_gold #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_gold (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage        (stage),
    .take         (take),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall),
    .symbol       (symbol)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the nr pbch dmrs generator core

module testbench;
  import pdmrs_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam int unsigned HOLDOFF_LEN  = 300;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    symbol_valid;
  logic    symbol_stall = 1'b0;
  symbol_t symbol;

  // stimulus knobs
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_left   = 0;

  int unsigned words_sent   = 0;
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;

  // gold sequence state of the predictor
  lfsr_t      gold_x1;
  lfsr_t      gold_x2;
  lfsr_t      x1_offset_state;
  logic [7:0] symbol_index;
  symbol_t    expected_symbols[$];

  nr_pbch_dmrs_generator_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall),
    .symbol       (symbol)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // x1 feeds back taps 0 and 3, x2 taps 0 through 3
  function automatic lfsr_t shift_x1(input lfsr_t s);
    return {^(s & lfsr_t'(9)), s[LFSR_W-1:1]};
  endfunction

  function automatic lfsr_t shift_x2(input lfsr_t s);
    return {^s[3:0], s[LFSR_W-1:1]};
  endfunction

  // next symbol from one accepted word
  task automatic predict_symbol(input item_t w);
    int unsigned seed;
    logic [1:0]  c;
    symbol_t     want;
    if (w.restart) begin
      seed = 2048 * (w.ssb_index + 1) * (w.cell_id / 4 + 1)
             + 64 * (w.ssb_index + 1) + w.cell_id % 4;
      gold_x1 = x1_offset_state;
      gold_x2 = lfsr_t'(seed);
      for (int i = 0; i < GOLD_NC; i++) gold_x2 = shift_x2(gold_x2);
      symbol_index = '0;
    end
    for (int i = 0; i < 2; i++) begin
      c[i]    = gold_x1[0] ^ gold_x2[0];
      gold_x1 = shift_x1(gold_x1);
      gold_x2 = shift_x2(gold_x2);
    end
    want.sym_re      = c[0] ? AMP_NEG : AMP_POS;
    want.sym_im      = c[1] ? AMP_NEG : AMP_POS;
    want.symbol_last = (symbol_index == DEF_NUM_SYM - 1);
    symbol_index     = want.symbol_last ? 8'd0 : symbol_index + 8'd1;
    expected_symbols.push_back(want);
  endtask

  task automatic report_mismatch(input string what, input symbol_t got,
                                 input symbol_t want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s, got %0d/%0d/%0b, want %0d/%0d/%0b",
               $time, what, got.sym_re, got.sym_im, got.symbol_last,
               want.sym_re, want.sym_im, want.symbol_last);
  endtask

  // check each accepted symbol, then predict from each accepted word
  always @(posedge clk) begin
    symbol_t want;
    if (!rst && symbol_valid && !symbol_stall) begin
      if (expected_symbols.size() == 0) begin
        report_mismatch("symbol with nothing expected", symbol, symbol);
      end else begin
        want = expected_symbols.pop_front();
        if (symbol.sym_re !== want.sym_re)
          report_mismatch("sym_re", symbol, want);
        if (symbol.sym_im !== want.sym_im)
          report_mismatch("sym_im", symbol, want);
        if (symbol.symbol_last !== want.symbol_last)
          report_mismatch("symbol_last", symbol, want);
      end
    end
    if (!rst && item_valid && !item_stall) predict_symbol(item);
  end

  // output side: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      symbol_stall <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      symbol_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (symbol_valid && !symbol_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // offer one word after random idle cycles and wait until it is taken
  task automatic send_word(input logic restart, input logic [CELL_W-1:0] pci,
                           input logic [SSB_W-1:0] ssb);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{restart: restart, cell_id: pci, ssb_index: ssb};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    words_sent++;
  endtask

  // fresh registers straight after reset: second register is zero
  task automatic test_no_restart_after_reset();
    send_word(1'b0, 10'h3FF, 3'd7);
    send_word(1'b0, 10'h000, 3'd0);
    send_word(1'b0, 10'h2AA, 3'd5);
    send_word(1'b0, 10'h155, 3'd2);
    send_word(1'b0, 10'h3FF, 3'd7);
  endtask

  // seed extremes, ids above the valid range and back-to-back restarts
  task automatic test_seed_extremes();
    send_word(1'b1, 10'd0, 3'd0);
    send_word(1'b0, 10'd0, 3'd0);
    send_word(1'b1, 10'd1007, 3'd7);
    send_word(1'b0, 10'd1007, 3'd7);
    send_word(1'b1, 10'd1023, 3'd7);
    send_word(1'b1, 10'd1008, 3'd0);
    send_word(1'b1, 10'd3, 3'd4);
    send_word(1'b1, 10'd512, 3'd1);
    send_word(1'b0, 10'h3FF, 3'd6);
    send_word(1'b0, 10'd0, 3'd3);
  endtask

  // mostly a restart and a run of symbols, some runs past the block end
  task automatic send_random_burst(input int unsigned budget);
    int unsigned pick;
    int unsigned run;
    pick = $urandom_range(99);
    if (pick < 40) run = DEF_NUM_SYM - 1;
    else if (pick < 80) run = $urandom_range(40);
    else run = $urandom_range(2 * DEF_NUM_SYM, DEF_NUM_SYM);
    // keep the phase within its word count
    if (run >= budget) run = budget - 1;
    send_word(($urandom_range(99) < 90), CELL_W'($urandom), SSB_W'($urandom));
    repeat (run)
      send_word(($urandom_range(99) < 2), CELL_W'($urandom), SSB_W'($urandom));
  endtask

  task automatic test_random_phase(input int unsigned idle_pct,
                                   input int unsigned stall_pct,
                                   input int unsigned words);
    int unsigned first;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first          = words_sent;
    while (words_sent - first < words)
      send_random_burst(words - (words_sent - first));
  endtask

  // hold the output off long enough for the block to back up its input
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_left   = HOLDOFF_LEN;
    send_word(1'b1, CELL_W'($urandom), SSB_W'($urandom));
    repeat (40) send_word(1'b0, CELL_W'($urandom), SSB_W'($urandom));
  endtask

  initial begin
    x1_offset_state = lfsr_t'(1);
    for (int i = 0; i < GOLD_NC; i++) x1_offset_state = shift_x1(x1_offset_state);
    gold_x1      = x1_offset_state;
    gold_x2      = '0;
    symbol_index = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_no_restart_after_reset();
    test_seed_extremes();
    test_random_phase(0, 0, 450);
    test_random_phase(57, 0, 450);
    test_random_phase(0, 57, 450);
    test_random_phase(32, 32, 450);
    test_output_holdoff();
    item_valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> nr_pbch_dmrs_generator_core.f
src/pdmrs_pkg.sv
src/pdmrs_front.sv
src/pdmrs_gold.sv
src/nr_pbch_dmrs_generator_core.sv
tb/sv/testbench.sv
